// ===== design/tli_pkg.sv =====
// shared types and constants of the table linear interpolator
// no dependencies
package tli_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W + 1;
  localparam int QFRAC_W    = 40;
  localparam int QUOT_W     = QFRAC_W + 1;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BELOW = 3'd1;
  localparam logic [2:0] ST_ABOVE = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_FEW   = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_SEL, S_RD0, S_RD1, S_CAP,
    S_CALC, S_MUL, S_DIVS, S_DIVW, S_EMIT
  } tli_state_t;

endpackage

// ===== design/table_linear_interpolator_top.sv =====
// table linear interpolator top level: point memory, search sequencer, arithmetic
// depends on tli_pkg and tli_div
//
// A write request (tuser 0) stores one point (abscissa, ordinate) in a 1024-entry
// memory. A query request (tuser 1) binary-searches that memory for the first
// abscissa not below the target, reads the two points of the segment and returns
// y0 + dy*dt/dx rounded and saturated (y0 if dx is zero, zero for under two
// points). A query runs its search steps (one memory read each, up to 11 steps for
// 1024 points), then fetch and multiply, then the bit-serial divider. Requests are
// taken one at a time; a finished result sits in the output register while the
// next request is accepted. The user must write point_count on cfg only while
// idle (the block leaves it unchecked); unwritten table entries read unspecified.
module table_linear_interpolator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_index[9:0], abscissa[41:10], ordinate[73:42], query_point[105:74], zero pad
  input  logic [111:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // interpolated[31:0], status[34:32], zero pad
  output logic [39:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [tli_pkg::CNT_W-1:0] cfg_data
);
  import tli_pkg::*;

  tli_state_t state_r, state_nxt;

  // point memory: {ordinate, abscissa}
  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] rdata_r;
  logic [IDX_W-1:0]    raddr;
  logic                we;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_r, n_nxt, lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IDX_W-1:0] seg_r, seg_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt, x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt;
  logic signed [DATA_W-1:0] y1_r, y1_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        neg_r, neg_nxt;
  logic [DATA_W:0]   mdy_r, mdy_nxt, mdt_r, mdt_nxt;
  logic [DATA_W-1:0] mdx_r, mdx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;

  logic         out_tvalid_r, out_tvalid_nxt;
  logic [39:0]  out_tdata_r, out_tdata_nxt;

  logic signed [DATA_W:0] dx, dy, dt;
  logic [2*DATA_W-1:0]    p00;
  logic                   div_start, div_done;
  logic [QUOT_W-1:0]      quot;
  logic signed [QUOT_W+1:0] sum;
  logic                   in_acc;
  logic [CNT_W-1:0]       mid_calc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign we        = in_acc && (in_tuser == KIND_WRITE);

  assign dx = DATA_W'(0) + {x1_r[DATA_W-1], x1_r} - {x0_r[DATA_W-1], x0_r};
  assign dy = {y1_r[DATA_W-1], y1_r} - {y0_r[DATA_W-1], y0_r};
  assign dt = {t_r[DATA_W-1], t_r} - {x0_r[DATA_W-1], x0_r};
  assign p00 = (2*DATA_W)'(mdy_r[DATA_W-1:0]) * (2*DATA_W)'(mdt_r[DATA_W-1:0]);
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign div_start = (state_r == S_DIVS);

  // signed quotient added to the left ordinate
  assign sum = {{2{y0_r[DATA_W-1]}}, {(QUOT_W-DATA_W){y0_r[DATA_W-1]}}, y0_r}
             + (neg_r ? -{2'b00, quot} : {2'b00, quot});

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (mdx_r),
    .done     (div_done),
    .quotient (quot)
  );

  // memory read address per sequencer step
  always_comb begin
    case (state_r)
      S_SRCH:  raddr = mid_calc[IDX_W-1:0];
      S_RD0:   raddr = seg_r;
      S_RD1:   raddr = seg_r + IDX_W'(1);
      default: raddr = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[in_tdata[IDX_W-1:0]] <= {in_tdata[73:42], in_tdata[41:10]};
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r;
    seg_nxt = seg_r; t_nxt = t_r;
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    st_nxt = st_r; neg_nxt = neg_r;
    mdy_nxt = mdy_r; mdt_nxt = mdt_r; mdx_nxt = mdx_r;
    prod_nxt = prod_r; res_nxt = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == KIND_QUERY) begin
          n_nxt  = (count_r > MAX_CNT) ? MAX_CNT : count_r;
          t_nxt  = in_tdata[105:74];
          lo_nxt = '0;
          hi_nxt = n_nxt;
          st_nxt = ST_OK;
          if (n_nxt < CNT_W'(2)) begin
            res_nxt   = '0;
            st_nxt    = ST_FEW;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        mid_nxt = mid_calc;
        state_nxt = (lo_r < hi_r) ? S_SCMP : S_SEL;
      end
      S_SCMP: begin
        if ($signed(rdata_r[DATA_W-1:0]) < t_r) lo_nxt = mid_r + CNT_W'(1);
        else hi_nxt = mid_r;
        state_nxt = S_SRCH;
      end
      S_SEL: begin
        if (lo_r == n_r) begin
          seg_nxt = IDX_W'(n_r - CNT_W'(2));
          st_nxt  = ST_ABOVE;
        end else if (lo_r == '0) begin
          seg_nxt = '0;
        end else begin
          seg_nxt = IDX_W'(lo_r - CNT_W'(1));
        end
        state_nxt = S_RD0;
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        x0_nxt = rdata_r[DATA_W-1:0];
        y0_nxt = rdata_r[2*DATA_W-1:DATA_W];
        state_nxt = S_CAP;
      end
      S_CAP: begin
        x1_nxt = rdata_r[DATA_W-1:0];
        y1_nxt = rdata_r[2*DATA_W-1:DATA_W];
        // below range only when search stopped at the first entry
        if (lo_r == '0 && t_r < x0_r) st_nxt = ST_BELOW;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (dx == '0) begin
          res_nxt   = y0_r;
          st_nxt    = ST_ZERO;
          state_nxt = S_EMIT;
        end else begin
          neg_nxt = dy[DATA_W] ^ dt[DATA_W] ^ dx[DATA_W];
          mdy_nxt = dy[DATA_W] ? -dy : dy;
          mdt_nxt = dt[DATA_W] ? -dt : dt;
          mdx_nxt = DATA_W'(dx[DATA_W] ? -dx : dx);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // 33x33 magnitude product from one 32x32 core and top-bit terms
        prod_nxt = PROD_W'(p00)
                 + (mdy_r[DATA_W] ? {1'b0, mdt_r[DATA_W-1:0], DATA_W'(0)} : '0)
                 + (mdt_r[DATA_W] ? {1'b0, mdy_r[DATA_W-1:0], DATA_W'(0)} : '0)
                 + ((mdy_r[DATA_W] && mdt_r[DATA_W]) ? {1'b1, (2*DATA_W)'(0)} : '0);
        state_nxt = S_DIVS;
      end
      S_DIVS: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          if (sum > (QUOT_W+2)'(32'sh7fffffff)) res_nxt = 32'sh7fffffff;
          else if (sum < -(QUOT_W+2)'(33'sh080000000)) res_nxt = 32'sh80000000;
          else res_nxt = sum[DATA_W-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, st_r, res_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) count_r <= cfg_data;
    end
    n_r <= n_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt;
    seg_r <= seg_nxt; t_r <= t_nxt;
    x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    st_r <= st_nxt; neg_r <= neg_nxt;
    mdy_r <= mdy_nxt; mdt_r <= mdt_nxt; mdx_r <= mdx_nxt;
    prod_r <= prod_nxt; res_r <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/tli_div.sv =====
// multicycle rounding divider: magnitude product over segment width
// depends on tli_pkg
module tli_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tli_pkg::PROD_W-1:0]  dividend,
  input  logic [tli_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [tli_pkg::QUOT_W-1:0]  quotient
);
  import tli_pkg::*;

  logic [DATA_W-1:0]  rem_r, rem_nxt;
  logic [QFRAC_W-1:0] sh_r, sh_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               fin_r, fin_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DATA_W:0]    trial;
  logic [DATA_W:0]    rem2;
  logic               ovf;

  // quotient would reach 2^40
  assign ovf  = {7'd0, dividend} >= {divisor, QFRAC_W'(0)};
  assign trial = {rem_r, sh_r[QFRAC_W-1]};
  assign rem2  = {rem_r, 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    ovf_nxt  = ovf_r;
    if (start) begin
      ovf_nxt  = ovf;
      rem_nxt  = DATA_W'(dividend[PROD_W-1:QFRAC_W]);
      sh_nxt   = dividend[QFRAC_W-1:0];
      cnt_nxt  = 6'(QFRAC_W);
      busy_nxt = !ovf;
      fin_nxt  = ovf;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DATA_W'(trial - {1'b0, divisor});
        sh_nxt  = {sh_r[QFRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DATA_W-1:0];
        sh_nxt  = {sh_r[QFRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = fin_r;
  // round half away from zero on the magnitude
  always_comb begin
    if (ovf_r) quotient = {1'b1, QFRAC_W'(0)};
    else if (rem2 >= {1'b0, divisor}) quotient = {1'b0, sh_r} + QUOT_W'(1);
    else quotient = {1'b0, sh_r};
  end

endmodule

// ===== design/tli_checker.sv =====
// port-level checker for the table linear interpolator, bound to the top level
// depends on tli_pkg and table_linear_interpolator_top ports
module tli_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata
);
  import tli_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // status code within range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[34:32] <= ST_FEW)
    else $error("bad status");

  // too few points gives zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] == ST_FEW |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero value with too few points");

  // a write request never makes a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result after write request");

  // a query request keeps the input busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input ready during query");

endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
